// ===== sv/dual_uart_frame_receiver_assert.svh =====
// Assertion macros shared by the frame receiver RTL.
`ifndef DUAL_UART_FRAME_RECEIVER_ASSERT_SVH
`define DUAL_UART_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define DUFR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frame receiver check failed");

// Next-cycle implication, disabled while reset is high.
`define DUFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frame receiver check failed");

`endif

// ===== sv/dufr_pkg.sv =====
`default_nettype none

package dufr_pkg;

   // Buffer geometry
   localparam int BUF_LEN = 256;
   localparam int ADDR_W  = $clog2(BUF_LEN);
   localparam int POS_W   = $clog2(BUF_LEN + 1);

   // Line terminator characters
   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;

   // Configuration register indexes
   localparam logic [2:0] CSR_HEADER_FIRST   = 3'd0;
   localparam logic [2:0] CSR_HEADER_SECOND  = 3'd1;
   localparam logic [2:0] CSR_HEADER_THIRD   = 3'd2;
   localparam logic [2:0] CSR_TRAILER_FIRST  = 3'd3;
   localparam logic [2:0] CSR_TRAILER_SECOND = 3'd4;

   typedef enum logic [1:0] {
      KIND_BYTE = 2'd0,
      KIND_READ = 2'd1,
      KIND_ACK  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_TAKEN = 3'd0,
      ST_FRAME = 3'd1,
      ST_LINE  = 3'd2,
      ST_ERROR = 3'd3,
      ST_HELD  = 3'd4,
      ST_READ  = 3'd5,
      ST_ACK   = 3'd6
   } status_type;

   typedef enum logic [3:0] {
      FS_HDR1 = 4'd0,
      FS_HDR2 = 4'd1,
      FS_HDR3 = 4'd2,
      FS_LENH = 4'd3,
      FS_LENL = 4'd4,
      FS_DATA = 4'd5,
      FS_SUM  = 4'd6,
      FS_TRL1 = 4'd7,
      FS_TRL2 = 4'd8
   } frame_state_type;

   typedef enum logic [1:0] {
      OWN_NONE  = 2'd0,
      OWN_FRAME = 2'd1,
      OWN_LINE  = 2'd2
   } owner_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
      logic [7:0] read_index;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [8:0] message_length;
      logic [7:0] read_data;
      logic       binary_mode;
   } rsp_type;

endpackage

`default_nettype wire

// ===== sv/dual_uart_frame_receiver.sv =====
// A request transaction passes through the input register, then the result register
// holding status and buffer read data, before its result is presented.
// Throughput: one transaction per cycle, sustained while the result side does not stall.
// Reset (synchronous, active high) clears both parsers, text mode, length and pending
// message; the buffer contents stay undefined until written and need no clearing pass.
`default_nettype none

`include "dual_uart_frame_receiver_assert.svh"

module dual_uart_frame_receiver (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire dufr_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output dufr_pkg::rsp_type     rsp_data,
   input  wire logic             csr_wr_en,
   input  wire logic [2:0]       csr_index,
   input  wire logic [7:0]       csr_wr_data
);

   // Configuration registers
   logic [7:0] hdr1_ff, hdr2_ff, hdr3_ff, trl1_ff, trl2_ff;

   // Input register
   logic              req_valid_ff;
   dufr_pkg::req_type req_ff;

   // Parser state
   dufr_pkg::frame_state_type frame_ff, frame_in;
   logic                      line_ff, line_in;
   logic                      mode_ff, mode_in;
   logic [7:0]                sum_ff, sum_in;
   logic [15:0]               exp_ff, exp_in;
   logic [dufr_pkg::POS_W-1:0] wp_ff, wp_in;
   dufr_pkg::owner_type       pend_ff, pend_in;

   // Result register
   logic                 rsp_valid_ff;
   dufr_pkg::status_type status_ff, status_in;
   logic                 rd_ok_ff, rd_ok_in;
   logic [7:0]           mem_q;

   // Buffer
   logic [7:0]                  mem [dufr_pkg::BUF_LEN];
   logic                        mem_we;
   logic [dufr_pkg::ADDR_W-1:0] mem_wa;

   // Decode helpers
   logic                        adv, fire, byte_go, entered;
   logic [7:0]                  b;
   logic                        b_hf;
   dufr_pkg::frame_state_type   fail_state;
   logic [15:0]                 len_word;
   logic [dufr_pkg::POS_W-1:0]  data_wp;
   logic [dufr_pkg::POS_W-1:0]  line_pos;

   // Handshake: the result stage moves when empty or drained
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign fire      = req_valid_ff && adv;
   assign req_stall = req_valid_ff && !adv;
   assign rsp_valid = rsp_valid_ff;

   assign b          = req_ff.data_byte;
   assign b_hf       = (b == hdr1_ff);
   assign byte_go    = fire && (req_ff.kind == dufr_pkg::KIND_BYTE)
                       && (pend_ff == dufr_pkg::OWN_NONE);
   assign fail_state = b_hf ? dufr_pkg::FS_HDR2 : dufr_pkg::FS_HDR1;
   assign len_word   = {exp_ff[15:8], b};
   assign data_wp    = (wp_ff < dufr_pkg::POS_W'(dufr_pkg::BUF_LEN))
                       ? wp_ff + dufr_pkg::POS_W'(1) : wp_ff;
   assign rd_ok_in   = (req_ff.kind == dufr_pkg::KIND_READ)
                       && ({1'b0, req_ff.read_index} < wp_ff);

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         hdr1_ff <= '0;
         hdr2_ff <= '0;
         hdr3_ff <= '0;
         trl1_ff <= '0;
         trl2_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            dufr_pkg::CSR_HEADER_FIRST:   hdr1_ff <= csr_wr_data;
            dufr_pkg::CSR_HEADER_SECOND:  hdr2_ff <= csr_wr_data;
            dufr_pkg::CSR_HEADER_THIRD:   hdr3_ff <= csr_wr_data;
            dufr_pkg::CSR_TRAILER_FIRST:  trl1_ff <= csr_wr_data;
            dufr_pkg::CSR_TRAILER_SECOND: trl2_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // Input register: take a new transaction whenever not stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         req_valid_ff <= req_valid;
      end
      if (req_valid && !req_stall) begin
         req_ff <= req_data;
      end
   end

   // Binary parser next state
   always_comb begin
      frame_in = frame_ff;
      if (byte_go) begin
         unique case (frame_ff)
            dufr_pkg::FS_HDR1: frame_in = b_hf ? dufr_pkg::FS_HDR2 : dufr_pkg::FS_HDR1;
            dufr_pkg::FS_HDR2: frame_in = (b == hdr2_ff) ? dufr_pkg::FS_HDR3 : fail_state;
            dufr_pkg::FS_HDR3: frame_in = (b == hdr3_ff) ? dufr_pkg::FS_LENH : fail_state;
            dufr_pkg::FS_LENH: frame_in = dufr_pkg::FS_LENL;
            dufr_pkg::FS_LENL: begin
               if (len_word > 16'(dufr_pkg::BUF_LEN)) begin
                  frame_in = dufr_pkg::FS_HDR1;
               end else if (len_word == 16'd0) begin
                  frame_in = dufr_pkg::FS_SUM;
               end else begin
                  frame_in = dufr_pkg::FS_DATA;
               end
            end
            dufr_pkg::FS_DATA: begin
               frame_in = ({{(16 - dufr_pkg::POS_W){1'b0}}, data_wp} >= exp_ff)
                          ? dufr_pkg::FS_SUM : dufr_pkg::FS_DATA;
            end
            dufr_pkg::FS_SUM:  frame_in = (b == sum_ff)  ? dufr_pkg::FS_TRL1 : fail_state;
            dufr_pkg::FS_TRL1: frame_in = (b == trl1_ff) ? dufr_pkg::FS_TRL2 : fail_state;
            dufr_pkg::FS_TRL2: frame_in = (b == trl2_ff) ? dufr_pkg::FS_HDR1 : fail_state;
            default:           frame_in = dufr_pkg::FS_HDR1;
         endcase
      end
   end

   // Datapath, status and buffer write for one transaction
   always_comb begin
      wp_in     = wp_ff;
      sum_in    = sum_ff;
      exp_in    = exp_ff;
      mode_in   = mode_ff;
      line_in   = line_ff;
      pend_in   = pend_ff;
      status_in = dufr_pkg::ST_TAKEN;
      mem_we    = 1'b0;
      mem_wa    = wp_ff[dufr_pkg::ADDR_W-1:0];
      entered   = 1'b0;
      line_pos  = '0;
      if (fire) begin
         unique case (req_ff.kind)
            dufr_pkg::KIND_BYTE: begin
               if (pend_ff != dufr_pkg::OWN_NONE) begin
                  status_in = dufr_pkg::ST_HELD;
               end else begin
                  // Binary parser sees every byte
                  unique case (frame_ff)
                     dufr_pkg::FS_HDR1: begin
                        if (b_hf) sum_in = '0;
                     end
                     dufr_pkg::FS_HDR3: begin
                        if (b == hdr3_ff) begin
                           mode_in = 1'b1;
                           line_in = 1'b0;
                           entered = 1'b1;
                        end
                     end
                     dufr_pkg::FS_LENH: begin
                        sum_in = sum_ff + b;
                        exp_in = {b, 8'h00};
                     end
                     dufr_pkg::FS_LENL: begin
                        sum_in = sum_ff + b;
                        exp_in = len_word;
                        wp_in  = '0;
                        if (len_word > 16'(dufr_pkg::BUF_LEN)) begin
                           mode_in   = 1'b0;
                           status_in = dufr_pkg::ST_ERROR;
                        end
                     end
                     dufr_pkg::FS_DATA: begin
                        sum_in = sum_ff + b;
                        wp_in  = data_wp;
                        mem_we = (wp_ff < dufr_pkg::POS_W'(dufr_pkg::BUF_LEN));
                     end
                     dufr_pkg::FS_SUM, dufr_pkg::FS_TRL1: begin
                        if ((frame_ff == dufr_pkg::FS_SUM && b != sum_ff)
                            || (frame_ff == dufr_pkg::FS_TRL1 && b != trl1_ff)) begin
                           mode_in   = 1'b0;
                           wp_in     = '0;
                           status_in = dufr_pkg::ST_ERROR;
                        end
                     end
                     dufr_pkg::FS_TRL2: begin
                        mode_in = 1'b0;
                        if (b != trl2_ff) begin
                           wp_in     = '0;
                           status_in = dufr_pkg::ST_ERROR;
                        end else begin
                           pend_in   = dufr_pkg::OWN_FRAME;
                           status_in = dufr_pkg::ST_FRAME;
                        end
                     end
                     default: ;
                  endcase
                  // Line collector runs in text mode unless the header just completed
                  if (!mode_ff && !entered) begin
                     status_in = dufr_pkg::ST_TAKEN;
                     if (!line_ff) begin
                        if (b == dufr_pkg::CHAR_CR) begin
                           line_in = 1'b1;
                        end else begin
                           line_pos = (wp_in >= dufr_pkg::POS_W'(dufr_pkg::BUF_LEN - 1))
                                      ? '0 : wp_in;
                           mem_we   = 1'b1;
                           mem_wa   = line_pos[dufr_pkg::ADDR_W-1:0];
                           wp_in    = line_pos + dufr_pkg::POS_W'(1);
                        end
                     end else begin
                        line_in = 1'b0;
                        if (b == dufr_pkg::CHAR_LF) begin
                           pend_in   = dufr_pkg::OWN_LINE;
                           status_in = dufr_pkg::ST_LINE;
                        end else begin
                           // restart the line with this byte
                           mem_we = 1'b1;
                           mem_wa = '0;
                           wp_in  = dufr_pkg::POS_W'(1);
                        end
                     end
                  end
               end
            end
            dufr_pkg::KIND_READ: status_in = dufr_pkg::ST_READ;
            dufr_pkg::KIND_ACK: begin
               status_in = dufr_pkg::ST_ACK;
               if (pend_ff != dufr_pkg::OWN_NONE) begin
                  pend_in = dufr_pkg::OWN_NONE;
                  wp_in   = '0;
               end
            end
            default: ;
         endcase
      end
   end

   // Parser state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= dufr_pkg::FS_HDR1;
         line_ff  <= 1'b0;
         mode_ff  <= 1'b0;
         sum_ff   <= '0;
         exp_ff   <= '0;
         wp_ff    <= '0;
         pend_ff  <= dufr_pkg::OWN_NONE;
      end else begin
         frame_ff <= frame_in;
         line_ff  <= line_in;
         mode_ff  <= mode_in;
         sum_ff   <= sum_in;
         exp_ff   <= exp_in;
         wp_ff    <= wp_in;
         pend_ff  <= pend_in;
      end
   end

   // Buffer write and registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= b;
      end
      if (fire) begin
         mem_q <= mem[req_ff.read_index];
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= req_valid_ff;
      end
      if (fire) begin
         status_ff <= status_in;
         rd_ok_ff  <= rd_ok_in;
      end
   end

   // Length and mode are the state left by the last transaction
   always_comb begin
      rsp_data.status         = status_ff;
      rsp_data.message_length = wp_ff;
      rsp_data.read_data      = rd_ok_ff ? mem_q : 8'h00;
      rsp_data.binary_mode    = mode_ff;
   end

   `DUFR_ASSERT_NOW(a_held_no_write, clock, reset, pend_ff != dufr_pkg::OWN_NONE, !mem_we)
   `DUFR_ASSERT_NOW(a_text_in_header, clock, reset, !mode_ff, frame_ff <= dufr_pkg::FS_HDR3)
   `DUFR_ASSERT_NOW(a_data_below_len, clock, reset, frame_ff == dufr_pkg::FS_DATA, {7'b0, wp_ff} < exp_ff)
   `DUFR_ASSERT_NOW(a_frame_done_owner, clock, reset, rsp_valid_ff && status_ff == dufr_pkg::ST_FRAME, !mode_ff && pend_ff == dufr_pkg::OWN_FRAME)
   `DUFR_ASSERT_NEXT(a_enter_binary, clock, reset, entered, mode_ff && !line_ff && frame_ff == dufr_pkg::FS_LENH)

endmodule

`default_nettype wire

// ===== tb/dual_uart_frame_receiver_test.sv =====
`timescale 1ns / 1ps

module dual_uart_frame_receiver_test;
   import dufr_pkg::*;

   // Kind code with no operation behind it
   localparam logic [1:0] KIND_SPARE = 2'd3;
   localparam int LATENCY = 2;
   // Roughly 1700 transactions at worst-case gap, stall and latency each, with margin
   localparam int CYCLE_LIMIT = 600000;

   typedef enum logic [1:0] {
      FLAW_NONE,
      FLAW_SUM,
      FLAW_TRL1,
      FLAW_TRL2
   } flaw_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic [2:0] csr_index = '0;
   logic [7:0] csr_wr_data = '0;

   // Shadow copy of the receiver: registers and parser state
   logic [7:0] hdr_first, hdr_second, hdr_third, trl_first, trl_second;
   frame_state_type frame_phase;
   logic line_armed;
   logic binary_only;
   logic [7:0] frame_sum;
   logic [15:0] frame_len;
   logic [8:0] buf_fill;
   owner_type msg_owner;
   logic [7:0] msg_buf [BUF_LEN];

   rsp_type awaited_rsp_q [$];
   status_type last_status;
   int status_tally [8];
   int fail_count = 0;
   int cycle_count = 0;
   int items_sent = 0;
   int settings_used = 0;
   int stall_left = 0;
   bit quiet_run = 1'b0;

   dual_uart_frame_receiver uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #2 clock = ~clock;

   // Append one byte to the message buffer while there is room
   function automatic void put_byte(logic [7:0] b);
      if (buf_fill < BUF_LEN) begin
         msg_buf[buf_fill[ADDR_W-1:0]] = b;
         buf_fill = buf_fill + 9'd1;
      end
   endfunction

   // Abort the frame: back to text mode, resync on a header start byte
   function automatic status_type fail_frame(logic [7:0] b);
      frame_phase = (b == hdr_first) ? FS_HDR2 : FS_HDR1;
      binary_only = 1'b0;
      buf_fill = '0;
      return ST_ERROR;
   endfunction

   // Binary frame parser; entered goes high when the header completes
   function automatic status_type frame_step(logic [7:0] b, output logic entered);
      entered = 1'b0;
      case (frame_phase)
         FS_HDR1: begin
            if (b == hdr_first) begin
               frame_phase = FS_HDR2;
               frame_sum = '0;
            end
         end
         FS_HDR2: begin
            if (b == hdr_second) frame_phase = FS_HDR3;
            else frame_phase = (b == hdr_first) ? FS_HDR2 : FS_HDR1;
         end
         FS_HDR3: begin
            if (b == hdr_third) begin
               frame_phase = FS_LENH;
               binary_only = 1'b1;
               line_armed = 1'b0;
               entered = 1'b1;
            end else begin
               frame_phase = (b == hdr_first) ? FS_HDR2 : FS_HDR1;
            end
         end
         FS_LENH: begin
            frame_sum = frame_sum + b;
            frame_len = {b, 8'h00};
            frame_phase = FS_LENL;
         end
         FS_LENL: begin
            frame_sum = frame_sum + b;
            frame_len = {frame_len[15:8], b};
            buf_fill = '0;
            if (frame_len > BUF_LEN) begin
               frame_phase = FS_HDR1;
               binary_only = 1'b0;
               return ST_ERROR;
            end
            frame_phase = (frame_len == 16'd0) ? FS_SUM : FS_DATA;
         end
         FS_DATA: begin
            put_byte(b);
            frame_sum = frame_sum + b;
            if (buf_fill >= frame_len) frame_phase = FS_SUM;
         end
         FS_SUM: begin
            if (b != frame_sum) return fail_frame(b);
            frame_phase = FS_TRL1;
         end
         FS_TRL1: begin
            if (b != trl_first) return fail_frame(b);
            frame_phase = FS_TRL2;
         end
         FS_TRL2: begin
            if (b != trl_second) return fail_frame(b);
            msg_owner = OWN_FRAME;
            frame_phase = FS_HDR1;
            binary_only = 1'b0;
            return ST_FRAME;
         end
         default: frame_phase = FS_HDR1;
      endcase
      return ST_TAKEN;
   endfunction

   // Text line collector, ends on CR LF
   function automatic status_type line_step(logic [7:0] b);
      if (!line_armed) begin
         if (b == CHAR_CR) line_armed = 1'b1;
         else begin
            if (buf_fill >= BUF_LEN - 1) buf_fill = '0;
            put_byte(b);
         end
         return ST_TAKEN;
      end
      line_armed = 1'b0;
      if (b == CHAR_LF) begin
         msg_owner = OWN_LINE;
         return ST_LINE;
      end
      buf_fill = '0;
      put_byte(b);
      return ST_TAKEN;
   endfunction

   // Work out the response to one accepted transaction and advance the shadow state
   function automatic rsp_type receiver_response(req_type r);
      rsp_type o;
      logic entered;
      o = '0;
      o.status = ST_TAKEN;
      case (r.kind)
         KIND_BYTE: begin
            if (msg_owner != OWN_NONE) o.status = ST_HELD;
            else if (binary_only) o.status = frame_step(r.data_byte, entered);
            else begin
               o.status = frame_step(r.data_byte, entered);
               if (!entered) o.status = line_step(r.data_byte);
            end
         end
         KIND_READ: begin
            o.status = ST_READ;
            if ({1'b0, r.read_index} < buf_fill) o.read_data = msg_buf[r.read_index];
         end
         KIND_ACK: begin
            o.status = ST_ACK;
            if (msg_owner != OWN_NONE) begin
               msg_owner = OWN_NONE;
               buf_fill = '0;
            end
         end
         default: ;
      endcase
      o.message_length = buf_fill;
      o.binary_mode = binary_only;
      return o;
   endfunction

   task automatic report_failure(string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      fail_count++;
   endtask

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         stall_left = quiet_run ? 0 : $urandom_range(0, 5);
         if (awaited_rsp_q.size() == 0) begin
            report_failure("result transaction with nothing expected");
         end else begin
            want = awaited_rsp_q.pop_front();
            status_tally[want.status]++;
            if (rsp_data.status !== want.status)
               report_failure($sformatf("status %0d, expected %0d",
                                        rsp_data.status, want.status));
            if (rsp_data.message_length !== want.message_length)
               report_failure($sformatf("message_length %0d, expected %0d",
                                        rsp_data.message_length, want.message_length));
            if (rsp_data.read_data !== want.read_data)
               report_failure($sformatf("read_data %0h, expected %0h",
                                        rsp_data.read_data, want.read_data));
            if (rsp_data.binary_mode !== want.binary_mode)
               report_failure($sformatf("binary_mode %0b, expected %0b",
                                        rsp_data.binary_mode, want.binary_mode));
         end
      end
   end

   // Hold off each result for the drawn number of cycles
   always @(negedge clock) begin
      if (rsp_valid === 1'b1 && stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("cycle limit hit, %0d results outstanding", awaited_rsp_q.size());
         $display("dual_uart_frame_receiver_test NOT OK");
         $finish;
      end
   end

   // Send one request transaction and record its expected result
   task automatic drive_request(logic [1:0] kind, logic [7:0] data, logic [7:0] idx);
      req_type r;
      rsp_type want;
      int gap;
      r.kind = kind;
      r.data_byte = data;
      r.read_index = idx;
      gap = quiet_run ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      want = receiver_response(r);
      awaited_rsp_q.push_back(want);
      last_status = status_type'(want.status);
      items_sent++;
      @(negedge clock);
   endtask

   // Drop valid and wait until every result is back
   task automatic drain_responses();
      req_valid <= 1'b0;
      while (awaited_rsp_q.size() != 0) @(negedge clock);
      repeat (LATENCY + 2) @(negedge clock);
   endtask

   task automatic write_register(logic [2:0] idx, logic [7:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= value;
      @(negedge clock);
      case (idx)
         CSR_HEADER_FIRST:   hdr_first = value;
         CSR_HEADER_SECOND:  hdr_second = value;
         CSR_HEADER_THIRD:   hdr_third = value;
         CSR_TRAILER_FIRST:  trl_first = value;
         CSR_TRAILER_SECOND: trl_second = value;
         default: ;
      endcase
   endtask

   task automatic set_config(logic [7:0] h1, logic [7:0] h2, logic [7:0] h3,
                             logic [7:0] t1, logic [7:0] t2);
      drain_responses();
      write_register(CSR_HEADER_FIRST, h1);
      write_register(CSR_HEADER_SECOND, h2);
      write_register(CSR_HEADER_THIRD, h3);
      write_register(CSR_TRAILER_FIRST, t1);
      write_register(CSR_TRAILER_SECOND, t2);
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   task automatic read_some();
      int n;
      logic [7:0] idx;
      n = $urandom_range(0, 3);
      repeat (n) begin
         if (buf_fill != 0 && $urandom_range(0, 3) != 0)
            idx = 8'($urandom_range(0, buf_fill - 1));
         else idx = 8'($urandom);
         drive_request(KIND_READ, 8'($urandom), idx);
      end
   endtask

   task automatic acknowledge();
      drive_request(KIND_ACK, 8'($urandom), 8'($urandom));
   endtask

   // Feed one UART byte; retry after acknowledge while a message holds it off
   task automatic push_byte(logic [7:0] b);
      drive_request(KIND_BYTE, b, 8'($urandom));
      while (last_status == ST_HELD) begin
         read_some();
         acknowledge();
         drive_request(KIND_BYTE, b, 8'($urandom));
      end
      // Release a finished message now, or leave it pending to hold later bytes
      if ((last_status == ST_FRAME || last_status == ST_LINE) && $urandom_range(0, 1) == 1) begin
         read_some();
         acknowledge();
      end
   endtask

   // Corrupt a byte, often into the header start so the search resyncs
   function automatic logic [7:0] spoil(logic [7:0] good);
      logic [7:0] delta;
      if (good != hdr_first && $urandom_range(0, 1) == 1) return hdr_first;
      delta = 8'($urandom_range(1, 255));
      return good + delta;
   endfunction

   task automatic send_frame(int len, flaw_type flaw);
      logic [15:0] len16;
      logic [7:0] sum;
      logic [7:0] b;
      int i;
      len16 = 16'(len);
      push_byte(hdr_first);
      push_byte(hdr_second);
      push_byte(hdr_third);
      push_byte(len16[15:8]);
      push_byte(len16[7:0]);
      if (len > BUF_LEN) return;
      sum = len16[15:8] + len16[7:0];
      for (i = 0; i < len; i++) begin
         b = 8'($urandom);
         sum = sum + b;
         push_byte(b);
      end
      push_byte(flaw == FLAW_SUM ? spoil(sum) : sum);
      if (flaw == FLAW_SUM) return;
      push_byte(flaw == FLAW_TRL1 ? spoil(trl_first) : trl_first);
      if (flaw == FLAW_TRL1) return;
      push_byte(flaw == FLAW_TRL2 ? spoil(trl_second) : trl_second);
   endtask

   task automatic send_line(int len, bit broken);
      logic [7:0] b;
      int i;
      for (i = 0; i < len; i++) begin
         b = 8'($urandom);
         if (b == CHAR_CR && $urandom_range(0, 3) != 0) b = ~b;
         push_byte(b);
      end
      push_byte(CHAR_CR);
      if (broken) begin
         b = 8'($urandom);
         if (b == CHAR_LF) b = ~b;
         push_byte(b);
      end else begin
         push_byte(CHAR_LF);
      end
   endtask

   function automatic int random_frame_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 2) return BUF_LEN;
      if (r < 6) return $urandom_range(BUF_LEN + 1, 65535);
      if (r < 25) return $urandom_range(9, 40);
      return $urandom_range(0, 8);
   endfunction

   function automatic flaw_type random_flaw();
      case ($urandom_range(0, 9))
         0: return FLAW_SUM;
         1: return FLAW_TRL1;
         2: return FLAW_TRL2;
         default: return FLAW_NONE;
      endcase
   endfunction

   // All registers still zero after reset
   task automatic test_default_registers();
      send_frame(1, FLAW_NONE);
      read_some();
      acknowledge();
      send_line(4, 1'b0);
      acknowledge();
   endtask

   // Field extremes, every kind and the parser corner cases
   task automatic test_directed_cases();
      set_config(8'hFF, 8'h00, 8'h7E, 8'h81, 8'h42);
      drive_request(KIND_SPARE, 8'hFF, 8'hFF);
      // acknowledge and read with nothing pending or stored
      drive_request(KIND_ACK, 8'h00, 8'h00);
      drive_request(KIND_READ, 8'h00, 8'h00);
      // CR CR restarts with CR stored, CR LF ends the line
      drive_request(KIND_BYTE, 8'h00, 8'h00);
      drive_request(KIND_BYTE, 8'h7F, 8'h00);
      drive_request(KIND_BYTE, CHAR_CR, 8'h00);
      drive_request(KIND_BYTE, CHAR_CR, 8'h00);
      drive_request(KIND_BYTE, 8'h55, 8'h00);
      drive_request(KIND_BYTE, CHAR_CR, 8'h00);
      drive_request(KIND_BYTE, CHAR_LF, 8'h00);
      // byte held while the line is pending, reads in and out of range
      drive_request(KIND_BYTE, 8'h31, 8'h00);
      drive_request(KIND_READ, 8'h00, 8'h00);
      drive_request(KIND_READ, 8'h00, 8'hFF);
      drive_request(KIND_ACK, 8'h00, 8'h00);
      // repeated header start, then a zero length frame
      drive_request(KIND_BYTE, 8'hFF, 8'h00);
      drive_request(KIND_BYTE, 8'hFF, 8'h00);
      drive_request(KIND_BYTE, 8'h00, 8'h00);
      drive_request(KIND_BYTE, 8'h7E, 8'h00);
      drive_request(KIND_BYTE, 8'h00, 8'h00);
      drive_request(KIND_BYTE, 8'h00, 8'h00);
      drive_request(KIND_BYTE, 8'h00, 8'h00);
      drive_request(KIND_BYTE, 8'h81, 8'h00);
      drive_request(KIND_BYTE, 8'h42, 8'h00);
      drive_request(KIND_ACK, 8'hFF, 8'hFF);
   endtask

   task automatic test_frame_errors();
      set_config(8'hC3, 8'h3C, 8'h99, 8'hE7, 8'h18);
      send_frame(BUF_LEN + 1, FLAW_NONE);
      send_frame(65535, FLAW_NONE);
      send_frame(3, FLAW_SUM);
      send_frame(2, FLAW_TRL1);
      send_frame(5, FLAW_TRL2);
      // bad checksum equal to the header start resyncs mid header
      push_byte(8'hC3);
      push_byte(8'h3C);
      push_byte(8'h99);
      push_byte(8'h00);
      push_byte(8'h01);
      push_byte(8'h10);
      push_byte(8'hC3);
      push_byte(8'h3C);
      push_byte(8'h99);
      push_byte(8'h00);
      push_byte(8'h00);
      push_byte(8'h00);
      push_byte(8'hE7);
      push_byte(8'h18);
      read_some();
      acknowledge();
   endtask

   // Line longer than the buffer wraps; full size frame fills it
   task automatic test_long_messages();
      set_config(8'h5A, 8'hA5, 8'h3C, 8'hC3, 8'h96);
      send_line(300, 1'b0);
      drive_request(KIND_READ, 8'($urandom), 8'd0);
      acknowledge();
      send_frame(BUF_LEN, FLAW_NONE);
      drive_request(KIND_READ, 8'($urandom), 8'hFF);
      drive_request(KIND_READ, 8'($urandom), 8'h00);
      acknowledge();
   endtask

   task automatic test_random_traffic();
      int phase;
      int stop_at;
      int phase_end;
      int pick;
      stop_at = 1400;
      phase = 0;
      while (items_sent < stop_at) begin
         case (phase % 6)
            0: set_config(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
            1: set_config(CHAR_CR, CHAR_LF, CHAR_CR, CHAR_LF, CHAR_CR);
            2: set_config(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
            default: set_config(8'($urandom), 8'($urandom), 8'($urandom),
                                8'($urandom), 8'($urandom));
         endcase
         quiet_run = (phase % 3 == 1);
         phase_end = items_sent + 120;
         while (items_sent < phase_end && items_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) send_frame(random_frame_len(), random_flaw());
            else if (pick < 75) send_line($urandom_range(0, 12), $urandom_range(0, 7) == 0);
            else if (pick < 85) repeat ($urandom_range(1, 4)) push_byte(8'($urandom));
            else if (pick < 92) read_some();
            else if (pick < 96) acknowledge();
            else if (pick < 98) drive_request(KIND_SPARE, 8'($urandom), 8'($urandom));
            else drain_responses();
         end
         phase++;
      end
      quiet_run = 1'b0;
   endtask

   initial begin
      hdr_first = '0;
      hdr_second = '0;
      hdr_third = '0;
      trl_first = '0;
      trl_second = '0;
      frame_phase = FS_HDR1;
      line_armed = 1'b0;
      binary_only = 1'b0;
      frame_sum = '0;
      frame_len = '0;
      buf_fill = '0;
      msg_owner = OWN_NONE;
      foreach (msg_buf[i]) msg_buf[i] = '0;
      foreach (status_tally[i]) status_tally[i] = 0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_default_registers();
      test_directed_cases();
      test_frame_errors();
      test_long_messages();
      test_random_traffic();
      drain_responses();

      $display("covered %0d transactions over %0d register settings", items_sent,
               settings_used + 1);
      $display("frames %0d, lines %0d, frame errors %0d, held bytes %0d, reads %0d",
               status_tally[ST_FRAME], status_tally[ST_LINE], status_tally[ST_ERROR],
               status_tally[ST_HELD], status_tally[ST_READ]);
      if (fail_count == 0) begin
         $display("dual_uart_frame_receiver_test OK");
      end else begin
         $display("dual_uart_frame_receiver_test NOT OK");
      end
      $finish;
   end

endmodule
